// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted (active low)
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`endif

// next-cycle implication, disabled while reset is asserted (active low)
`ifndef NO_ASSERTIONS
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== design/rftm_pkg.sv =====
package rftm_pkg;

    // framing bytes sent by the reader ahead of each code
    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_LF = 8'h0A;

    // default table geometry
    localparam int NUM_TAGS_DEF = 16;
    localparam int CODE_LEN_DEF = 14;

    // field widths fixed by the interface
    localparam int CFG_W  = 5;
    localparam int ID_W   = 5;
    localparam int TIDX_W = 4;
    localparam int CPOS_W = 4;

    // compare request broadcast to every cell
    typedef struct packed {
        logic       en;
        logic       last;
        logic [7:0] data;
    } rftm_cmp_t;

endpackage

// ===== design/rftm_cell.sv =====
module rftm_cell #(
    parameter int CODE_LEN = rftm_pkg::CODE_LEN_DEF,
    parameter int POS_W    = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [POS_W-1:0]      wr_addr,
    input  logic [7:0]            wr_data,
    input  logic [7:0]            wr_code,
    input  rftm_pkg::rftm_cmp_t   cmp,
    input  logic [POS_W-1:0]      cmp_addr,
    input  logic                  shift_en,
    input  logic                  flag_in,
    output logic                  flag_out
);
    import rftm_pkg::*;

    logic [7:0]          chars_reg [CODE_LEN];
    logic [CODE_LEN-1:0] eq_reg;
    logic [CODE_LEN-1:0] eq_next;
    logic                flag_reg;
    logic                flag_next;
    logic                char_eq;

    // stored tag characters, loaded by software
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            chars_reg[wr_addr] <= wr_data;
        end
    end

    assign char_eq = (chars_reg[cmp_addr] == cmp.data);

    // per-character match bits, a table write re-checks its character against the code
    always_comb begin
        eq_next = eq_reg;
        if (cmp.en) begin
            eq_next[cmp_addr] = char_eq;
        end else if (wr_en) begin
            eq_next[wr_addr] = (wr_data == wr_code);
        end
    end

    always_ff @(posedge aclk) begin
        eq_reg <= eq_next;
    end

    // match flag loaded at the last code byte, shifted toward the head for the result scan
    always_comb begin
        flag_next = flag_reg;
        if (cmp.en && cmp.last) begin
            flag_next = &eq_next;
        end else if (shift_en) begin
            flag_next = flag_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg <= 1'b0;
        end else begin
            flag_reg <= flag_next;
        end
    end

    assign flag_out = flag_reg;

endmodule

// ===== design/rfid_frame_tag_matcher_unit.sv =====
// Tag reader frame matcher.
// s_ channel: one request per cycle at most. s_tuser selects the kind: 0 is a
// received serial byte, 1 writes one character of the tag table.
// A received byte with read_enable low is dropped. The framer waits for 0x0D,
// then 0x0A, then collects CODE_LEN code bytes; each code byte is compared
// in the same cycle by every cell of the chain against its stored entry, and
// a table write during a frame compares the new character with the code byte.
// After the last code byte the match flags shift through the chain toward the
// head, one cell per cycle while m_ is free, and the first hit among the first
// tags_in_use entries gives user_id. The result appears on m_ once that scan
// ends; s_tready is low during the scan.
// All other requests complete as they are accepted.
// Only a completed frame gives a result. m_ holds one result in an output
// register; while it is stalled the scan pauses, and other requests are still
// taken when no scan is running.
// cfg_wr_en writes tags_in_use; write it only while the block is idle.
// Reset (aresetn low, synchronous) returns the framer to waiting for 0x0D,
// clears tags_in_use and m_tvalid; the tag table keeps its contents and
// must be loaded before use.
module rfid_frame_tag_matcher_unit #(
    parameter int NUM_TAGS = rftm_pkg::NUM_TAGS_DEF,
    parameter int CODE_LEN = rftm_pkg::CODE_LEN_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [rftm_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // data_byte[7:0], read_enable[8], tag_index[12:9], char_position[16:13]
    input  logic [23:0]                s_tdata,
    // operation[0]
    input  logic [0:0]                 s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // user_id[4:0], matched[5]
    output logic [7:0]                 m_tdata
);
    import rftm_pkg::*;

    localparam int POS_W = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
    localparam int CNT_W = (NUM_TAGS > 1) ? $clog2(NUM_TAGS) : 1;

    localparam logic [1:0] ST_WAIT_CR  = 2'd0;
    localparam logic [1:0] ST_WAIT_LF  = 2'd1;
    localparam logic [1:0] ST_COLLECT  = 2'd2;

    // request fields
    logic [7:0]        in_data;
    logic              in_rd_en;
    logic [TIDX_W-1:0] in_tidx;
    logic [CPOS_W-1:0] in_cpos;
    logic              in_op;
    logic              s_accept;
    logic              rx_accept;
    logic [31:0]       cpos_ext;
    logic              cpos_ok;

    assign in_data  = s_tdata[7:0];
    assign in_rd_en = s_tdata[8];
    assign in_tidx  = s_tdata[12:9];
    assign in_cpos  = s_tdata[16:13];
    assign in_op    = s_tuser[0];

    assign s_accept  = s_tvalid && s_tready;
    assign rx_accept = s_accept && !in_op && in_rd_en;
    assign cpos_ext  = 32'(in_cpos);
    assign cpos_ok   = (cpos_ext < 32'(CODE_LEN));

    // registers
    logic [CFG_W-1:0] tags_in_use_reg;
    logic [1:0]       state_reg, state_next;
    logic [POS_W-1:0] byte_cnt_reg, byte_cnt_next;
    logic             scan_reg, scan_next;
    logic [CNT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_data_reg, m_data_next;
    logic [7:0]       code_buf_reg [CODE_LEN];

    rftm_cmp_t        cmp;
    logic             last_byte;
    logic             out_free;
    logic             scan_step;
    logic             hit;
    logic             last_cnt;
    logic             finish;
    logic [31:0]      id_wide;
    logic [7:0]       wr_code;
    logic [NUM_TAGS:0] flag_chain;

    assign s_tready = !scan_reg;
    assign last_byte = (byte_cnt_reg == POS_W'(CODE_LEN - 1));

    // framing state machine
    always_comb begin
        state_next    = state_reg;
        byte_cnt_next = byte_cnt_reg;
        cmp.en        = 1'b0;
        cmp.last      = last_byte;
        cmp.data      = in_data;
        if (rx_accept) begin
            case (state_reg)
                ST_COLLECT: begin
                    cmp.en = 1'b1;
                    if (last_byte) begin
                        byte_cnt_next = '0;
                        state_next    = ST_WAIT_CR;
                    end else begin
                        byte_cnt_next = byte_cnt_reg + 1'b1;
                    end
                end
                ST_WAIT_LF: begin
                    if (in_data == BYTE_LF) begin
                        state_next = ST_COLLECT;
                    end
                    byte_cnt_next = '0;
                end
                default: begin
                    state_next = (in_data == BYTE_CR) ? ST_WAIT_LF : ST_WAIT_CR;
                end
            endcase
        end
    end

    // code bytes of the frame being collected
    always_ff @(posedge aclk) begin
        if (cmp.en) begin
            code_buf_reg[byte_cnt_reg] <= in_data;
        end
    end

    assign wr_code = code_buf_reg[cpos_ext[POS_W-1:0]];

    // result scan over the shifting match flags
    assign out_free  = !m_valid_reg || m_tready;
    assign scan_step = scan_reg && out_free;
    assign hit       = flag_chain[0] && (32'(scan_cnt_reg) < 32'(tags_in_use_reg));
    assign last_cnt  = (scan_cnt_reg == CNT_W'(NUM_TAGS - 1));
    assign finish    = scan_step && (hit || last_cnt);
    assign id_wide   = hit ? (32'(scan_cnt_reg) + 32'd1) : 32'd0;

    always_comb begin
        scan_next     = scan_reg;
        scan_cnt_next = scan_cnt_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        if (cmp.en && last_byte) begin
            scan_next     = 1'b1;
            scan_cnt_next = '0;
        end else if (finish) begin
            scan_next = 1'b0;
        end else if (scan_step) begin
            scan_cnt_next = scan_cnt_reg + 1'b1;
        end
        if (finish) begin
            m_valid_next = 1'b1;
            m_data_next  = {2'b00, hit, id_wide[ID_W-1:0]};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tags_in_use_reg <= '0;
            state_reg       <= ST_WAIT_CR;
            byte_cnt_reg    <= '0;
            scan_reg        <= 1'b0;
            scan_cnt_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                tags_in_use_reg <= cfg_wr_data;
            end
            state_reg    <= state_next;
            byte_cnt_reg <= byte_cnt_next;
            scan_reg     <= scan_next;
            scan_cnt_reg <= scan_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // chain of tag cells, flags move toward cell 0
    assign flag_chain[NUM_TAGS] = 1'b0;

    for (genvar i = 0; i < NUM_TAGS; i++) begin : g_cell
        logic wr_sel;
        assign wr_sel = s_accept && in_op && cpos_ok && (32'(in_tidx) == 32'(i));

        rftm_cell #(
            .CODE_LEN (CODE_LEN),
            .POS_W    (POS_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .wr_en    (wr_sel),
            .wr_addr  (cpos_ext[POS_W-1:0]),
            .wr_data  (in_data),
            .wr_code  (wr_code),
            .cmp      (cmp),
            .cmp_addr (byte_cnt_reg),
            .shift_en (scan_step),
            .flag_in  (flag_chain[i+1]),
            .flag_out (flag_chain[i])
        );
    end

    // checks
    `include "assert_macros.svh"

    `ASSERT_IMPLIES(a_no_accept_in_scan, aclk, aresetn, scan_reg, !s_tready)
    `ASSERT_NEXT(a_scan_after_frame, aclk, aresetn, cmp.en && last_byte, scan_reg)
    `ASSERT_IMPLIES(a_match_flag, aclk, aresetn, m_valid_reg, m_data_reg[5] == (m_data_reg[4:0] != '0))
    `ASSERT_IMPLIES(a_collect_only_count, aclk, aresetn, state_reg != ST_COLLECT, byte_cnt_reg == '0)
    `ASSERT_NEXT(a_scan_ends_in_result, aclk, aresetn, finish, m_valid_reg && !scan_reg)

endmodule
